>>> rtl/scattering_direction_basis_defines.svh
// Assertion macros used by the checker file of scattering_direction_basis.
// No dependencies.
`ifndef SCATTERING_DIRECTION_BASIS_DEFINES_SVH
`define SCATTERING_DIRECTION_BASIS_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define SDB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdb check failed");

// Next-cycle implication, off while reset is high.
`define SDB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdb check failed");

`endif

>>> rtl/sdb_pkg.sv
// Package for scattering_direction_basis: widths, sine polynomial constants
// and the stage word carried along the cell chain. No dependencies.
`timescale 1ns / 1ps
package sdb_pkg;

   localparam int ANGLE_W  = 16;
   localparam int Z_W      = 15;
   localparam int SQ_W     = 2 * Z_W;
   localparam int ACC_W    = 31;
   localparam int MUL_W    = ACC_W + Z_W;
   localparam int Q14      = 14;
   localparam int Q15      = 15;
   localparam int SCALED_W = MUL_W - Q14;
   localparam int MAG_W    = 15;
   localparam int COMP_W   = 16;
   localparam int PROD_W   = 2 * COMP_W;
   localparam int LANES    = 4;
   localparam int DEPTH    = 5;
   localparam int FLIGHT_W = 4;

   // Q30 coefficients of A z - B z^3 + C z^5
   localparam logic [ACC_W-1:0] SIN_A = 31'd1686629713;
   localparam logic [ACC_W-1:0] SIN_B = 31'd688904866;
   localparam logic [ACC_W-1:0] SIN_C = 31'd76016977;

   localparam logic [ANGLE_W-1:0]  QUARTER_TURN = 16'd16384;
   localparam logic [Z_W-1:0]      Z_ONE        = 15'd16384;
   localparam logic [SQ_W-1:0]     SQ_ROUND     = 30'd8192;
   localparam logic [SCALED_W-1:0] MAG_ROUND    = 32'd16384;
   localparam logic [MAG_W-1:0]    MAG_MAX      = 15'h7FFF;

   localparam logic signed [PROD_W-1:0] PROD_ROUND = 32'sd16384;
   localparam logic signed [PROD_W-1:0] PROD_HI    = 32'sd32767;
   localparam logic signed [PROD_W-1:0] PROD_LO    = -32'sd32768;

   localparam logic [1:0] LANE_SIN_T = 2'd0;
   localparam logic [1:0] LANE_COS_T = 2'd1;
   localparam logic [1:0] LANE_SIN_P = 2'd2;
   localparam logic [1:0] LANE_COS_P = 2'd3;

   typedef struct packed {
      logic [Z_W-1:0]   z;
      logic [Z_W-1:0]   z2;
      logic [ACC_W-1:0] acc;
      logic             neg;
   } lane_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      logic                 last;
   } word_type;

endpackage

>>> rtl/sdb_if.sv
// Valid/ready channel interfaces for scattering_direction_basis.
// Depends on sdb_pkg.
`timescale 1ns / 1ps
interface sdb_req_if;
   logic                        valid;
   logic                        ready;
   logic [sdb_pkg::ANGLE_W-1:0] theta;
   logic [sdb_pkg::ANGLE_W-1:0] phi;
   logic                        last_direction;

   modport source (output valid, theta, phi, last_direction, input ready);
   modport sink   (input valid, theta, phi, last_direction, output ready);
endinterface

interface sdb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [sdb_pkg::COMP_W-1:0] dir_x;
   logic signed [sdb_pkg::COMP_W-1:0] dir_y;
   logic signed [sdb_pkg::COMP_W-1:0] dir_z;
   logic signed [sdb_pkg::COMP_W-1:0] par_x;
   logic signed [sdb_pkg::COMP_W-1:0] par_y;
   logic signed [sdb_pkg::COMP_W-1:0] par_z;
   logic signed [sdb_pkg::COMP_W-1:0] perp_y;
   logic signed [sdb_pkg::COMP_W-1:0] perp_z;
   logic                              last_result;

   modport source (output valid, dir_x, dir_y, dir_z, par_x, par_y, par_z,
                   perp_y, perp_z, last_result, input ready);
   modport sink   (input valid, dir_x, dir_y, dir_z, par_x, par_y, par_z,
                   perp_y, perp_z, last_result, output ready);
endinterface

>>> rtl/sdb_front.sv
// First cell: quadrant fold and squaring of the four angles.
// Depends on sdb_pkg and sdb_if.
`timescale 1ns / 1ps
module sdb_front (
   input  logic              clock,
   input  logic              reset,
   sdb_req_if.sink           req,
   output logic              out_valid,
   input  logic              out_ready,
   output sdb_pkg::word_type out_word
);

   function automatic sdb_pkg::lane_type fold(input logic [sdb_pkg::ANGLE_W-1:0] angle);
      logic [sdb_pkg::Z_W-1:0]  r;
      logic [sdb_pkg::Z_W-1:0]  z;
      logic [sdb_pkg::SQ_W-1:0] sq;
      sdb_pkg::lane_type        l;
      r     = {1'b0, angle[sdb_pkg::Q14-1:0]};
      z     = angle[sdb_pkg::Q14] ? (sdb_pkg::Z_ONE - r) : r;
      sq    = sdb_pkg::SQ_W'(z) * sdb_pkg::SQ_W'(z) + sdb_pkg::SQ_ROUND;
      l.z   = z;
      l.z2  = sq[sdb_pkg::Z_W+sdb_pkg::Q14-1:sdb_pkg::Q14];
      l.acc = sdb_pkg::SIN_C;
      l.neg = angle[sdb_pkg::Q15];
      return l;
   endfunction

   logic              valid_ff;
   logic              valid_in;
   sdb_pkg::word_type word_ff;
   sdb_pkg::word_type word_in;

   assign req.ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req.ready) begin
         valid_in = req.valid;
         word_in.lane[sdb_pkg::LANE_SIN_T] = fold(req.theta);
         word_in.lane[sdb_pkg::LANE_COS_T] =
            fold(sdb_pkg::ANGLE_W'(req.theta + sdb_pkg::QUARTER_TURN));
         word_in.lane[sdb_pkg::LANE_SIN_P] = fold(req.phi);
         word_in.lane[sdb_pkg::LANE_COS_P] =
            fold(sdb_pkg::ANGLE_W'(req.phi + sdb_pkg::QUARTER_TURN));
         word_in.last = req.last_direction;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> rtl/sdb_horner_cell.sv
// One Horner cell of the sine polynomial: acc <= coef - (acc * z2 >> 14),
// four lanes wide. Depends on sdb_pkg.
`timescale 1ns / 1ps
module sdb_horner_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [sdb_pkg::ACC_W-1:0] coef,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  sdb_pkg::word_type         in_word,
   output logic                      out_valid,
   input  logic                      out_ready,
   output sdb_pkg::word_type         out_word
);

   logic                      valid_ff;
   logic                      valid_in;
   sdb_pkg::word_type         word_ff;
   sdb_pkg::word_type         word_in;
   logic [sdb_pkg::MUL_W-1:0] prod [sdb_pkg::LANES];

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int i = 0; i < sdb_pkg::LANES; i++) begin
         prod[i] = sdb_pkg::MUL_W'(in_word.lane[i].acc) * sdb_pkg::MUL_W'(in_word.lane[i].z2);
      end
      valid_in = valid_ff;
      word_in  = word_ff;
      if (in_ready) begin
         valid_in = in_valid;
         word_in  = in_word;
         for (int i = 0; i < sdb_pkg::LANES; i++) begin
            word_in.lane[i].acc =
               coef - prod[i][sdb_pkg::ACC_W+sdb_pkg::Q14-1:sdb_pkg::Q14];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> rtl/sdb_back.sv
// Last two cells: sine scaling to Q1.15 with saturation and sign, then the
// basis products into the result register. Depends on sdb_pkg and sdb_if.
`timescale 1ns / 1ps
module sdb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sdb_pkg::word_type in_word,
   sdb_rsp_if.source         rsp
);

   function automatic logic signed [sdb_pkg::COMP_W-1:0] mul_q15(
      input logic signed [sdb_pkg::COMP_W-1:0] a,
      input logic signed [sdb_pkg::COMP_W-1:0] b
   );
      logic signed [sdb_pkg::PROD_W-1:0] p;
      logic signed [sdb_pkg::PROD_W-1:0] q;
      logic signed [sdb_pkg::COMP_W-1:0] v;
      p = a * b;
      q = (p + sdb_pkg::PROD_ROUND) >>> sdb_pkg::Q15;
      if (q > sdb_pkg::PROD_HI) begin
         v = sdb_pkg::PROD_HI[sdb_pkg::COMP_W-1:0];
      end else if (q < sdb_pkg::PROD_LO) begin
         v = sdb_pkg::PROD_LO[sdb_pkg::COMP_W-1:0];
      end else begin
         v = q[sdb_pkg::COMP_W-1:0];
      end
      return v;
   endfunction

   logic signed [sdb_pkg::COMP_W-1:0]  sin_ff [sdb_pkg::LANES];
   logic signed [sdb_pkg::COMP_W-1:0]  sin_in [sdb_pkg::LANES];
   logic                               sin_valid_ff;
   logic                               sin_valid_in;
   logic                               sin_last_ff;
   logic                               sin_last_in;
   logic                               sin_ready;
   logic [sdb_pkg::MUL_W-1:0]          prod [sdb_pkg::LANES];
   logic [sdb_pkg::SCALED_W-1:0]       rsum [sdb_pkg::LANES];
   logic [sdb_pkg::SCALED_W-sdb_pkg::Q15-1:0] mag_wide [sdb_pkg::LANES];
   logic [sdb_pkg::MAG_W-1:0]          mag [sdb_pkg::LANES];
   logic signed [sdb_pkg::COMP_W-1:0]  mag_s [sdb_pkg::LANES];

   logic                               valid_ff, valid_in;
   logic signed [sdb_pkg::COMP_W-1:0]  dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic signed [sdb_pkg::COMP_W-1:0]  dir_z_ff, dir_z_in, par_x_ff, par_x_in;
   logic signed [sdb_pkg::COMP_W-1:0]  par_y_ff, par_y_in, par_z_ff, par_z_in;
   logic signed [sdb_pkg::COMP_W-1:0]  perp_y_ff, perp_y_in, perp_z_ff, perp_z_in;
   logic                               last_ff, last_in;

   assign sin_ready = !valid_ff || rsp.ready;
   assign in_ready  = !sin_valid_ff || sin_ready;

   // sine finish: s = u * z >> 14, Q15 magnitude rounded, clamped, signed
   always_comb begin
      for (int i = 0; i < sdb_pkg::LANES; i++) begin
         prod[i] = sdb_pkg::MUL_W'(in_word.lane[i].acc) * sdb_pkg::MUL_W'(in_word.lane[i].z);
         rsum[i] = prod[i][sdb_pkg::MUL_W-1:sdb_pkg::Q14] + sdb_pkg::MAG_ROUND;
         mag_wide[i] = rsum[i][sdb_pkg::SCALED_W-1:sdb_pkg::Q15];
         mag[i] = (mag_wide[i] > (sdb_pkg::SCALED_W-sdb_pkg::Q15)'(sdb_pkg::MAG_MAX)) ?
                  sdb_pkg::MAG_MAX : mag_wide[i][sdb_pkg::MAG_W-1:0];
         mag_s[i] = $signed({1'b0, mag[i]});
      end
      sin_valid_in = sin_valid_ff;
      sin_last_in  = sin_last_ff;
      for (int i = 0; i < sdb_pkg::LANES; i++) begin
         sin_in[i] = sin_ff[i];
      end
      if (in_ready) begin
         sin_valid_in = in_valid;
         sin_last_in  = in_word.last;
         for (int i = 0; i < sdb_pkg::LANES; i++) begin
            sin_in[i] = in_word.lane[i].neg ? -mag_s[i] : mag_s[i];
         end
      end
   end

   // basis products into the result register
   always_comb begin
      valid_in  = valid_ff;
      dir_x_in  = dir_x_ff;
      dir_y_in  = dir_y_ff;
      dir_z_in  = dir_z_ff;
      par_x_in  = par_x_ff;
      par_y_in  = par_y_ff;
      par_z_in  = par_z_ff;
      perp_y_in = perp_y_ff;
      perp_z_in = perp_z_ff;
      last_in   = last_ff;
      if (sin_ready) begin
         valid_in  = sin_valid_ff;
         dir_x_in  = sin_ff[sdb_pkg::LANE_COS_T];
         dir_y_in  = mul_q15(sin_ff[sdb_pkg::LANE_SIN_T], sin_ff[sdb_pkg::LANE_COS_P]);
         dir_z_in  = mul_q15(sin_ff[sdb_pkg::LANE_SIN_T], sin_ff[sdb_pkg::LANE_SIN_P]);
         par_x_in  = -sin_ff[sdb_pkg::LANE_SIN_T];
         par_y_in  = mul_q15(sin_ff[sdb_pkg::LANE_COS_T], sin_ff[sdb_pkg::LANE_COS_P]);
         par_z_in  = mul_q15(sin_ff[sdb_pkg::LANE_COS_T], sin_ff[sdb_pkg::LANE_SIN_P]);
         perp_y_in = -sin_ff[sdb_pkg::LANE_SIN_P];
         perp_z_in = sin_ff[sdb_pkg::LANE_COS_P];
         last_in   = sin_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         sin_valid_ff <= sin_valid_in;
         valid_ff     <= valid_in;
      end
      for (int i = 0; i < sdb_pkg::LANES; i++) begin
         sin_ff[i] <= sin_in[i];
      end
      sin_last_ff <= sin_last_in;
      dir_x_ff    <= dir_x_in;
      dir_y_ff    <= dir_y_in;
      dir_z_ff    <= dir_z_in;
      par_x_ff    <= par_x_in;
      par_y_ff    <= par_y_in;
      par_z_ff    <= par_z_in;
      perp_y_ff   <= perp_y_in;
      perp_z_ff   <= perp_z_in;
      last_ff     <= last_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.dir_x       = dir_x_ff;
   assign rsp.dir_y       = dir_y_ff;
   assign rsp.dir_z       = dir_z_ff;
   assign rsp.par_x       = par_x_ff;
   assign rsp.par_y       = par_y_ff;
   assign rsp.par_z       = par_z_ff;
   assign rsp.perp_y      = perp_y_ff;
   assign rsp.perp_z      = perp_z_ff;
   assign rsp.last_result = last_ff;

endmodule

>>> rtl/scattering_direction_basis.sv
// Five-cell pipeline: angles in, propagation and polarization basis out.
// Each cell is a register stage with its own valid bit; ready runs back down
// the row, so an empty cell always takes data and bubbles close up behind a
// stalled result. One direction per cycle sustained while rsp is not stalled;
// each direction is registered by each cell in turn (fold and square, two
// Horner cells of the sine polynomial, sine scaling, basis products) before
// rsp valid rises. Up to five directions are held at once.
// No state is carried between directions.
// Depends on sdb_pkg, sdb_if, sdb_front, sdb_horner_cell and sdb_back.
`timescale 1ns / 1ps
module scattering_direction_basis (
   input  logic      clock,
   input  logic      reset,
   sdb_req_if.sink   req_ch,
   sdb_rsp_if.source rsp_ch
);

   logic              front_valid, front_ready;
   logic              cell_b_valid, cell_b_ready;
   logic              cell_a_valid, cell_a_ready;
   sdb_pkg::word_type front_word, cell_b_word, cell_a_word;

   sdb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_word  (front_word)
   );

   sdb_horner_cell u_cell_b (
      .clock     (clock),
      .reset     (reset),
      .coef      (sdb_pkg::SIN_B),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (cell_b_valid),
      .out_ready (cell_b_ready),
      .out_word  (cell_b_word)
   );

   sdb_horner_cell u_cell_a (
      .clock     (clock),
      .reset     (reset),
      .coef      (sdb_pkg::SIN_A),
      .in_valid  (cell_b_valid),
      .in_ready  (cell_b_ready),
      .in_word   (cell_b_word),
      .out_valid (cell_a_valid),
      .out_ready (cell_a_ready),
      .out_word  (cell_a_word)
   );

   sdb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cell_a_valid),
      .in_ready (cell_a_ready),
      .in_word  (cell_a_word),
      .rsp      (rsp_ch)
   );

endmodule

>>> rtl/sdb_checker.sv
// Port-level checks for scattering_direction_basis, bound to the top level.
// Depends on sdb_pkg and scattering_direction_basis_defines.svh.
`timescale 1ns / 1ps
`include "scattering_direction_basis_defines.svh"
module sdb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [sdb_pkg::COMP_W-1:0] dir_x,
   input logic signed [sdb_pkg::COMP_W-1:0] dir_y,
   input logic signed [sdb_pkg::COMP_W-1:0] dir_z,
   input logic signed [sdb_pkg::COMP_W-1:0] par_x,
   input logic signed [sdb_pkg::COMP_W-1:0] par_y,
   input logic signed [sdb_pkg::COMP_W-1:0] par_z,
   input logic signed [sdb_pkg::COMP_W-1:0] perp_y,
   input logic signed [sdb_pkg::COMP_W-1:0] perp_z,
   input logic                              last_result
);

   logic                         req_xfer;
   logic                         rsp_xfer;
   logic [sdb_pkg::FLIGHT_W-1:0] flight_ff;
   logic [sdb_pkg::FLIGHT_W-1:0] flight_in;
   logic [8*sdb_pkg::COMP_W:0]   rsp_word;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign rsp_word = {dir_x, dir_y, dir_z, par_x, par_y, par_z, perp_y, perp_z,
                      last_result};

   always_comb begin
      flight_in = flight_ff;
      if (req_xfer && !rsp_xfer) begin
         flight_in = flight_ff + sdb_pkg::FLIGHT_W'(1);
      end else if (!req_xfer && rsp_xfer) begin
         flight_in = flight_ff - sdb_pkg::FLIGHT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   `SDB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
   `SDB_ASSERT_NOW(a_idle_ready, clock, reset, !rsp_valid, req_ready)
   `SDB_ASSERT_NOW(a_rsp_has_item, clock, reset, rsp_valid, flight_ff != '0)
   `SDB_ASSERT_NOW(a_depth_bound, clock, reset, 1'b1, flight_ff <= sdb_pkg::FLIGHT_W'(sdb_pkg::DEPTH))

endmodule

bind scattering_direction_basis sdb_checker u_sdb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .dir_x       (rsp_ch.dir_x),
   .dir_y       (rsp_ch.dir_y),
   .dir_z       (rsp_ch.dir_z),
   .par_x       (rsp_ch.par_x),
   .par_y       (rsp_ch.par_y),
   .par_z       (rsp_ch.par_z),
   .perp_y      (rsp_ch.perp_y),
   .perp_z      (rsp_ch.perp_z),
   .last_result (rsp_ch.last_result)
);

>>> tb/sv/tb_top.sv
// Self-checking bench for scattering_direction_basis: edge-case and random angle
// pairs go in, and every basis vector that comes out is compared with a predicted value.
// Depends on sdb_pkg, sdb_if and the scattering_direction_basis RTL.
`timescale 1ns / 1ps
module tb_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 830;
   localparam int CALM_ITEMS   = 120;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] par_x;
      logic signed [15:0] par_y;
      logic signed [15:0] par_z;
      logic signed [15:0] perp_y;
      logic signed [15:0] perp_z;
      logic               last;
   } basis_type;

   class basis_ledger;
      localparam longint COEF_LIN   = 64'd1686629713;
      localparam longint COEF_CUBE  = 64'd688904866;
      localparam longint COEF_QUINT = 64'd76016977;

      basis_type pending_bases[$];
      int        mismatches;
      int        checked;

      function int turn_sine(input logic [15:0] ang);
         longint z, z2, p, t, u, s, mag;
         z = ang[14] ? 64'd16384 - longint'(ang[13:0]) : longint'(ang[13:0]);
         z2 = (z * z + 8192) >> 14;
         p = (COEF_QUINT * z2) >> 14;
         t = ((COEF_CUBE - p) * z2) >> 14;
         u = COEF_LIN - t;
         s = (u * z) >> 14;
         mag = (s + 16384) >> 15;
         if (mag > 32767) mag = 32767;
         return ang[15] ? -int'(mag) : int'(mag);
      endfunction

      function int turn_cosine(input logic [15:0] ang);
         return turn_sine(ang + 16'd16384);
      endfunction

      function int round_product(input int a, input int b);
         longint prod;
         prod = (longint'(a) * longint'(b) + 16384) >>> 15;
         if (prod > 32767) prod = 32767;
         if (prod < -32768) prod = -32768;
         return int'(prod);
      endfunction

      function basis_type predict_basis(input logic [15:0] theta, input logic [15:0] phi,
                                        input logic last_direction);
         basis_type b;
         int st, ct, sp, cp;
         st = turn_sine(theta);
         ct = turn_cosine(theta);
         sp = turn_sine(phi);
         cp = turn_cosine(phi);
         b.dir_x  = 16'(ct);
         b.dir_y  = 16'(round_product(st, cp));
         b.dir_z  = 16'(round_product(st, sp));
         b.par_x  = 16'(-st);
         b.par_y  = 16'(round_product(ct, cp));
         b.par_z  = 16'(round_product(ct, sp));
         b.perp_y = 16'(-sp);
         b.perp_z = 16'(cp);
         b.last   = last_direction;
         return b;
      endfunction

      function void note_direction(input logic [15:0] theta, input logic [15:0] phi,
                                   input logic last_direction);
         pending_bases.push_back(predict_basis(theta, phi, last_direction));
      endfunction

      task report(input string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task compare_field(input string field, input logic signed [15:0] got,
                         input logic signed [15:0] want);
         if (got !== want)
            report($sformatf("result %0d %s got %0d expected %0d", checked, field, got,
                             want));
      endtask

      task check_basis(input basis_type got);
         basis_type want;
         if (pending_bases.size() == 0) begin
            report($sformatf("result %0d arrived with no transfer pending", checked));
         end else begin
            want = pending_bases.pop_front();
            compare_field("dir_x", got.dir_x, want.dir_x);
            compare_field("dir_y", got.dir_y, want.dir_y);
            compare_field("dir_z", got.dir_z, want.dir_z);
            compare_field("par_x", got.par_x, want.par_x);
            compare_field("par_y", got.par_y, want.par_y);
            compare_field("par_z", got.par_z, want.par_z);
            compare_field("perp_y", got.perp_y, want.perp_y);
            compare_field("perp_z", got.perp_z, want.perp_z);
            compare_field("last_result", got.last, want.last);
         end
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   accepted      = 0;
   int   cycles        = 0;
   bit   stimulus_done = 1'b0;

   basis_ledger ledger = new();

   sdb_req_if req_ch();
   sdb_rsp_if rsp_ch();

   scattering_direction_basis i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   task automatic send_direction(input logic [15:0] theta, input logic [15:0] phi,
                                 input logic last_direction);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.theta          <= theta;
      req_ch.phi            <= phi;
      req_ch.last_direction <= last_direction;
      do @(posedge clock); while (!req_ch.ready);
      ledger.note_direction(theta, phi, last_direction);
      accepted++;
   endtask

   // angle near a quadrant boundary, where the sine folds and saturates
   function automatic logic [15:0] near_quadrant();
      return 16'($urandom_range(3) * 16384 + $urandom_range(16) - 8);
   endfunction

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(2))
         0: return near_quadrant();
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.theta          = '0;
      req_ch.phi            = '0;
      req_ch.last_direction = 1'b0;
      idle_pct              = 0;
      do @(posedge clock); while (reset);

      send_direction(16'd0, 16'd0, 1'b0);
      send_direction(16'd16384, 16'd0, 1'b0);
      send_direction(16'd32768, 16'd16384, 1'b0);
      send_direction(16'd49152, 16'd32768, 1'b0);
      send_direction(16'd65535, 16'd49152, 1'b1);
      send_direction(16'd0, 16'd65535, 1'b0);
      send_direction(16'd1, 16'd16383, 1'b0);
      send_direction(16'd16383, 16'd16385, 1'b0);
      send_direction(16'd16385, 16'd1, 1'b0);
      send_direction(16'd32767, 16'd32769, 1'b0);
      send_direction(16'd49151, 16'd49153, 1'b1);
      send_direction(16'd49153, 16'd65534, 1'b0);
      send_direction(16'd8192, 16'd8192, 1'b0);
      send_direction(16'd24576, 16'd40960, 1'b0);
      send_direction(16'd40960, 16'd57344, 1'b1);
      send_direction(16'd57344, 16'd24576, 1'b0);
      send_direction(16'h5555, 16'hAAAA, 1'b0);
      send_direction(16'hAAAA, 16'h5555, 1'b1);
      send_direction(16'hFFFF, 16'hFFFF, 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
            idle_pct = 0;
         end else if (i % 64 == 0) begin
            case ($urandom_range(2))
               0: idle_pct = 0;
               1: idle_pct = 20;
               default: idle_pct = 45;
            endcase
         end
         send_direction(pick_angle(), pick_angle(), $urandom_range(7) == 0);
      end
      req_ch.valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         ledger.check_basis('{rsp_ch.dir_x, rsp_ch.dir_y, rsp_ch.dir_z, rsp_ch.par_x,
                              rsp_ch.par_y, rsp_ch.par_z, rsp_ch.perp_y, rsp_ch.perp_z,
                              rsp_ch.last_result});
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transfers accepted", cycles, accepted);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!stimulus_done || ledger.pending_bases.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending_bases.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
